// ----- rtl/core/dtq_pkg.sv -----
`timescale 1ns / 1ps
package dtq_pkg;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;
    localparam int DELTA_W         = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_WALK = 2'd1,
        S_DONE = 2'd2
    } state_t;

    // row update applied to every cell in the same cycle
    typedef enum logic [1:0] {
        A_NONE = 2'd0,
        A_INS  = 2'd1,
        A_DEL  = 2'd2,
        A_MRG  = 2'd3
    } act_t;
endpackage

// ----- rtl/core/delta_timer_queue_unit.sv -----
`timescale 1ns / 1ps
// channel  | signals                                   | direction
// command  | start, opcode, task_id, sleep_ticks; busy  | in, busy out
// result   | done, status, popped_id, head_delta, ...  | out
// insert and remove walk the cell row entry by entry in S_WALK; pop acts on the head cell
// every command then passes S_DONE, and done is registered from S_DONE
// rst_n clears the entry count; the entry row holds no reset value
// start is taken only while busy is low; done is high one cycle, no stall
module delta_timer_queue_unit #(
    parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = dtq_pkg::ID_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [7:0]  task_id,
    input  logic [31:0] sleep_ticks,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  popped_id,
    output logic [31:0] head_delta,
    output logic        is_empty
);
    localparam int IDW = (ID_BITS < 8) ? ID_BITS : 8;

    dtq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (IDW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .task_id     (task_id[IDW-1:0]),
        .sleep_ticks (sleep_ticks),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .popped_id   (popped_id),
        .head_delta  (head_delta),
        .is_empty    (is_empty)
    );

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_empty) |-> head_delta == 32'd0) else $error("empty head not zero");
endmodule

// ----- rtl/core/dtq_cell.sv -----
`timescale 1ns / 1ps
module dtq_cell #(
    parameter int ID_BITS = dtq_pkg::ID_BITS_DEF,
    parameter int POS_W   = $clog2(dtq_pkg::QUEUE_DEPTH_DEF),
    parameter int IDX     = 0
) (
    input  logic                        clk,
    input  dtq_pkg::act_t               act,
    input  logic [POS_W-1:0]            act_pos,
    input  logic [ID_BITS-1:0]          key_id,
    input  logic [dtq_pkg::DELTA_W-1:0] key_delta,
    input  logic [ID_BITS-1:0]          prev_task,
    input  logic [dtq_pkg::DELTA_W-1:0] prev_delta,
    input  logic [ID_BITS-1:0]          next_task,
    input  logic [dtq_pkg::DELTA_W-1:0] next_delta,
    output logic [ID_BITS-1:0]          task_q,
    output logic [dtq_pkg::DELTA_W-1:0] delta_q
);
    localparam logic [POS_W-1:0] IDX_V    = POS_W'(IDX);
    localparam logic [POS_W-1:0] PRV_V    = POS_W'((IDX > 0) ? IDX - 1 : 0);
    localparam logic             HAS_PREV = (IDX > 0);

    logic [ID_BITS-1:0]          task_reg, task_next;
    logic [dtq_pkg::DELTA_W-1:0] delta_reg, delta_next;
    logic [dtq_pkg::DELTA_W:0]   sum;
    logic                        at_pos;
    logic                        above;
    logic                        just_after;

    assign at_pos     = (act_pos == IDX_V);
    assign above      = (IDX_V > act_pos);
    assign just_after = HAS_PREV && (act_pos == PRV_V);

    always_comb
    begin
        task_next  = task_reg;
        delta_next = delta_reg;
        sum        = {1'b0, next_delta} + {1'b0, delta_reg};
        case (act)
            dtq_pkg::A_INS:
            begin
                if (above)
                begin
                    // successor of the new entry loses the inserted delta
                    task_next  = prev_task;
                    delta_next = just_after ? prev_delta - key_delta : prev_delta;
                end
                else if (at_pos)
                begin
                    task_next  = key_id;
                    delta_next = key_delta;
                end
            end
            dtq_pkg::A_DEL:
            begin
                if (above || at_pos)
                begin
                    task_next  = next_task;
                    delta_next = next_delta;
                end
            end
            dtq_pkg::A_MRG:
            begin
                if (above)
                begin
                    task_next  = next_task;
                    delta_next = next_delta;
                end
                else if (at_pos)
                begin
                    // removed delta folds into the successor, saturating
                    task_next  = next_task;
                    delta_next = sum[dtq_pkg::DELTA_W] ? '1 : sum[dtq_pkg::DELTA_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        task_reg  <= task_next;
        delta_reg <= delta_next;
    end

    assign task_q  = task_reg;
    assign delta_q = delta_reg;
endmodule

// ----- rtl/core/dtq_ctrl.sv -----
`timescale 1ns / 1ps
module dtq_ctrl #(
    parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = dtq_pkg::ID_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  opcode,
    input  logic [ID_BITS-1:0]          task_id,
    input  logic [dtq_pkg::DELTA_W-1:0] sleep_ticks,
    output logic                        busy,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [7:0]                  popped_id,
    output logic [dtq_pkg::DELTA_W-1:0] head_delta,
    output logic                        is_empty
);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    dtq_pkg::state_t state_reg, state_next;
    dtq_pkg::op_t    op_reg;
    logic [ID_BITS-1:0]          id_reg;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               pos_reg, pos_next;
    logic [dtq_pkg::DELTA_W-1:0] rem_reg, rem_next;
    logic [1:0]                  st_reg, st_next;
    logic [7:0]                  pop_reg, pop_next;
    logic                        done_reg;

    // row of cells, index 0 is the head
    logic [ID_BITS-1:0]          cell_task [QUEUE_DEPTH];
    logic [dtq_pkg::DELTA_W-1:0] cell_delta[QUEUE_DEPTH];
    logic [dtq_pkg::DELTA_W-1:0] dcur;
    logic [ID_BITS-1:0]          tcur;
    logic [IW-1:0]               pos_idx;
    logic                        at_end;

    dtq_pkg::act_t act;
    logic [IW-1:0] act_pos;

    assign at_end  = (pos_reg >= count_reg);
    assign pos_idx = at_end ? '0 : pos_reg[IW-1:0];
    assign dcur    = cell_delta[pos_idx];
    assign tcur    = cell_task[pos_idx];
    assign act_pos = pos_reg[IW-1:0];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        st_next    = st_reg;
        pop_next   = pop_reg;
        act        = dtq_pkg::A_NONE;
        unique case (state_reg)
            dtq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    pos_next   = '0;
                    rem_next   = sleep_ticks;
                    st_next    = dtq_pkg::ST_OK;
                    pop_next   = '0;
                    state_next = dtq_pkg::S_WALK;
                end
            end
            dtq_pkg::S_WALK:
            begin
                state_next = dtq_pkg::S_DONE;
                unique case (op_reg)
                    dtq_pkg::OP_INSERT:
                    begin
                        if (count_reg >= CW'(QUEUE_DEPTH))
                            st_next = dtq_pkg::ST_FULL;
                        else if (!at_end && rem_reg >= dcur)
                        begin
                            rem_next   = rem_reg - dcur;
                            pos_next   = pos_reg + CW'(1);
                            state_next = dtq_pkg::S_WALK;
                        end
                        else
                        begin
                            act        = dtq_pkg::A_INS;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    dtq_pkg::OP_POP:
                    begin
                        if (count_reg == '0)
                            st_next = dtq_pkg::ST_MISS;
                        else
                        begin
                            pop_next   = 8'(cell_task[0]);
                            act        = dtq_pkg::A_DEL;
                            count_next = count_reg - CW'(1);
                        end
                    end
                    dtq_pkg::OP_REMOVE:
                    begin
                        if (at_end)
                            st_next = dtq_pkg::ST_MISS;
                        else if (tcur == id_reg)
                        begin
                            act        = dtq_pkg::A_MRG;
                            count_next = count_reg - CW'(1);
                        end
                        else
                        begin
                            pos_next   = pos_reg + CW'(1);
                            state_next = dtq_pkg::S_WALK;
                        end
                    end
                    dtq_pkg::OP_NONE: ;
                endcase
            end
            dtq_pkg::S_DONE:
            begin
                state_next = dtq_pkg::S_IDLE;
            end
            default: state_next = dtq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtq_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == dtq_pkg::S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        rem_reg <= rem_next;
        st_reg  <= st_next;
        pop_reg <= pop_next;
        if (state_reg == dtq_pkg::S_IDLE && start)
        begin
            op_reg <= dtq_pkg::op_t'(opcode);
            id_reg <= task_id;
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            logic [ID_BITS-1:0]          prev_task, next_task;
            logic [dtq_pkg::DELTA_W-1:0] prev_delta, next_delta;

            if (g == 0)
            begin : g_first
                assign prev_task  = '0;
                assign prev_delta = '0;
            end
            else
            begin : g_prev
                assign prev_task  = cell_task[g-1];
                assign prev_delta = cell_delta[g-1];
            end

            if (g == QUEUE_DEPTH - 1)
            begin : g_last
                assign next_task  = '0;
                assign next_delta = '0;
            end
            else
            begin : g_next
                assign next_task  = cell_task[g+1];
                assign next_delta = cell_delta[g+1];
            end

            dtq_cell #(
                .ID_BITS (ID_BITS),
                .POS_W   (IW),
                .IDX     (g)
            ) u_cell (
                .clk        (clk),
                .act        (act),
                .act_pos    (act_pos),
                .key_id     (id_reg),
                .key_delta  (rem_reg),
                .prev_task  (prev_task),
                .prev_delta (prev_delta),
                .next_task  (next_task),
                .next_delta (next_delta),
                .task_q     (cell_task[g]),
                .delta_q    (cell_delta[g])
            );
        end
    endgenerate

    assign busy       = (state_reg != dtq_pkg::S_IDLE);
    assign done       = done_reg;
    assign status     = st_reg;
    assign popped_id  = pop_reg;
    assign head_delta = (count_reg == '0) ? '0 : cell_delta[0];
    assign is_empty   = (count_reg == '0);
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    localparam int DEPTH = dtq_pkg::QUEUE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [7:0]  task_id;
    logic [31:0] sleep_ticks;
    logic        done;
    logic [1:0]  status;
    logic [7:0]  popped_id;
    logic [31:0] head_delta;
    logic        is_empty;

    delta_timer_queue_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .task_id(task_id), .sleep_ticks(sleep_ticks),
        .done(done), .status(status), .popped_id(popped_id),
        .head_delta(head_delta), .is_empty(is_empty)
    );

    typedef struct {
        dtq_pkg::status_t st;
        logic [7:0]       popped;
        logic [31:0]      head;
        logic             empty;
    } outcome_t;

    logic [7:0]  sleeper_id[DEPTH];
    logic [31:0] sleeper_delta[DEPTH];
    int          sleeper_count;
    outcome_t    pending_outcomes[$];

    int errors;
    int sent;
    int checked;
    int idle_cycles;
    int n_insert, n_pop, n_remove, n_full, n_miss;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // reference behavior of the sleep list
    function automatic outcome_t apply_command(dtq_pkg::op_t op, logic [7:0] id,
                                               logic [31:0] ticks);
        outcome_t r;
        int pos;
        logic [32:0] sum;
        r.st = dtq_pkg::ST_OK;
        r.popped = 8'd0;
        pos = 0;
        if (op == dtq_pkg::OP_INSERT)
        begin
            if (sleeper_count >= DEPTH)
                r.st = dtq_pkg::ST_FULL;
            else
            begin
                while (pos < sleeper_count && ticks >= sleeper_delta[pos])
                begin
                    ticks = ticks - sleeper_delta[pos];
                    pos++;
                end
                for (int k = sleeper_count; k > pos; k--)
                begin
                    sleeper_id[k] = sleeper_id[k-1];
                    sleeper_delta[k] = sleeper_delta[k-1];
                end
                sleeper_id[pos] = id;
                sleeper_delta[pos] = ticks;
                sleeper_count++;
                if (pos + 1 < sleeper_count)
                    sleeper_delta[pos+1] = sleeper_delta[pos+1] - ticks;
            end
        end
        else if (op == dtq_pkg::OP_POP)
        begin
            if (sleeper_count == 0)
                r.st = dtq_pkg::ST_MISS;
            else
            begin
                r.popped = sleeper_id[0];
                for (int k = 0; k + 1 < sleeper_count; k++)
                begin
                    sleeper_id[k] = sleeper_id[k+1];
                    sleeper_delta[k] = sleeper_delta[k+1];
                end
                sleeper_count--;
            end
        end
        else if (op == dtq_pkg::OP_REMOVE)
        begin
            r.st = dtq_pkg::ST_MISS;
            for (pos = 0; pos < sleeper_count; pos++)
            begin
                if (sleeper_id[pos] == id)
                begin
                    if (pos + 1 < sleeper_count)
                    begin
                        sum = {1'b0, sleeper_delta[pos+1]} + {1'b0, sleeper_delta[pos]};
                        sleeper_delta[pos+1] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    end
                    for (int k = pos; k + 1 < sleeper_count; k++)
                    begin
                        sleeper_id[k] = sleeper_id[k+1];
                        sleeper_delta[k] = sleeper_delta[k+1];
                    end
                    sleeper_count--;
                    r.st = dtq_pkg::ST_OK;
                    break;
                end
            end
        end
        r.head = sleeper_count != 0 ? sleeper_delta[0] : 32'd0;
        r.empty = sleeper_count == 0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s at result %0d: got %0h expected %0h", what, checked, got, want);
        errors++;
    endtask

    task automatic send_command(input dtq_pkg::op_t op, input logic [7:0] id,
                                input logic [31:0] ticks);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            opcode <= dtq_pkg::OP_NONE;
            task_id <= 8'($urandom);
            sleep_ticks <= $urandom;
            repeat (gap) @(negedge clk);
        end
        opcode <= op;
        task_id <= id;
        sleep_ticks <= ticks;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_outcomes.push_back(apply_command(op, id, ticks));
        case (op)
            dtq_pkg::OP_INSERT: n_insert++;
            dtq_pkg::OP_POP:    n_pop++;
            dtq_pkg::OP_REMOVE: n_remove++;
            default: ;
        endcase
        sent++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("unexpected transaction", 32'd1, 32'd0);
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.st)
                    report_mismatch("status", 32'(status), 32'(want.st));
                if (popped_id !== want.popped)
                    report_mismatch("popped_id", 32'(popped_id), 32'(want.popped));
                if (head_delta !== want.head)
                    report_mismatch("head_delta", head_delta, want.head);
                if (is_empty !== want.empty)
                    report_mismatch("is_empty", 32'(is_empty), 32'(want.empty));
                if (want.st == dtq_pkg::ST_FULL) n_full++;
                if (want.st == dtq_pkg::ST_MISS) n_miss++;
            end
            checked++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [31:0] random_ticks();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom;
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    function automatic logic [7:0] random_id();
        if (sleeper_count != 0 && $urandom_range(0, 2) != 0)
            return sleeper_id[$urandom_range(0, sleeper_count - 1)];
        return $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 7));
    endfunction

    task automatic test_empty_list();
        send_command(dtq_pkg::OP_POP, 8'd0, 32'd0);
        send_command(dtq_pkg::OP_REMOVE, 8'hFF, 32'd0);
        send_command(dtq_pkg::OP_NONE, 8'hAA, 32'h5555_5555);
    endtask

    task automatic test_extremes_and_merge();
        send_command(dtq_pkg::OP_INSERT, 8'hFF, 32'hFFFF_FFFF);
        send_command(dtq_pkg::OP_INSERT, 8'h00, 32'd0);
        send_command(dtq_pkg::OP_INSERT, 8'h55, 32'hFFFF_FFFF);
        send_command(dtq_pkg::OP_INSERT, 8'h07, 32'd0);
        send_command(dtq_pkg::OP_REMOVE, 8'h00, 32'd0);
        send_command(dtq_pkg::OP_REMOVE, 8'hFF, 32'd0);
        send_command(dtq_pkg::OP_INSERT, 8'h07, 32'h8000_0000);
        send_command(dtq_pkg::OP_REMOVE, 8'h07, 32'd0);
        send_command(dtq_pkg::OP_REMOVE, 8'h42, 32'd0);
        send_command(dtq_pkg::OP_NONE, 8'h55, 32'hAAAA_AAAA);
        send_command(dtq_pkg::OP_POP, 8'd0, 32'd0);
        send_command(dtq_pkg::OP_POP, 8'd0, 32'd0);
        send_command(dtq_pkg::OP_POP, 8'd0, 32'd0);
    endtask

    task automatic test_full_list();
        for (int i = 0; i <= DEPTH; i++)
            send_command(dtq_pkg::OP_INSERT, 8'(i), 32'(i * 3));
        for (int i = 0; i <= DEPTH; i++)
            send_command(dtq_pkg::OP_POP, 8'd0, 32'd0);
    endtask

    task automatic test_random_mix(input int count);
        dtq_pkg::op_t op;
        int bias;
        bias = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 200 == 0)
                bias = $urandom_range(0, 2);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op = dtq_pkg::OP_INSERT;
                4, 5:       op = dtq_pkg::OP_POP;
                6, 7, 8:    op = dtq_pkg::OP_REMOVE;
                default:    op = dtq_pkg::OP_NONE;
            endcase
            if (bias == 1 && op == dtq_pkg::OP_POP)
                op = dtq_pkg::OP_INSERT;
            if (bias == 2 && op == dtq_pkg::OP_INSERT && $urandom_range(0, 1) == 1)
                op = dtq_pkg::OP_POP;
            send_command(op, random_id(), random_ticks());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        opcode = dtq_pkg::OP_NONE;
        task_id = 8'd0;
        sleep_ticks = 32'd0;
        sleeper_count = 0;
        errors = 0;
        sent = 0;
        checked = 0;
        idle_cycles = 0;
        n_insert = 0; n_pop = 0; n_remove = 0; n_full = 0; n_miss = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_empty_list();
        test_extremes_and_merge();
        test_full_list();
        test_random_mix(1650);
        start <= 1'b0;
        opcode <= dtq_pkg::OP_NONE;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        $display("%0d commands: %0d inserts, %0d pops, %0d removes", sent, n_insert, n_pop,
                 n_remove);
        $display("%0d results checked, %0d full, %0d empty or not found", checked, n_full,
                 n_miss);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
